### rtl/fvt_pkg.sv
// ----------------------------------------------------------------------------
// FM LFO package
// Widths, dwell constants and register codes for the vibrato/tremolo LFO.
// ----------------------------------------------------------------------------
package fvt_pkg;

   localparam int FREQ_W    = 3;
   localparam int LEVEL_W   = 6;
   localparam int PHASE_W   = 6;
   localparam int TICK_W    = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 1;

   localparam logic [TICK_W-1:0] VIB_DWELL       = TICK_W'(1024);
   localparam logic [TICK_W-1:0] TREM_DWELL_LOW  = TICK_W'(64 * 7);
   localparam logic [TICK_W-1:0] TREM_DWELL_PEAK = TICK_W'(64 * 3);
   localparam logic [TICK_W-1:0] TREM_DWELL_MID  = TICK_W'(64 * 4);

   localparam logic [PHASE_W-1:0] TREM_STEPS = PHASE_W'(52);
   localparam logic [PHASE_W-1:0] TREM_PEAK  = PHASE_W'(26);
   localparam logic [PHASE_W-1:0] TREM_LAST  = PHASE_W'(51);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LFO_MODE  = 2'd0,
      CSR_DEPTH_OP0 = 2'd1,
      CSR_DEPTH_OP1 = 2'd2
   } csr_index_type;

   typedef logic signed [LEVEL_W-1:0] level_type;

endpackage

### rtl/fvt_if.sv
// ----------------------------------------------------------------------------
// FM LFO channels
// Valid/ready channels for tick items and level result items.
// ----------------------------------------------------------------------------
interface fvt_req_if;
   import fvt_pkg::*;

   logic                valid;
   logic                ready;
   logic [FREQ_W-1:0]   freq_top_bits;

   modport source (output valid, output freq_top_bits, input ready);
   modport sink   (input valid, input freq_top_bits, output ready);
endinterface

interface fvt_rsp_if;
   import fvt_pkg::*;

   logic                valid;
   logic                ready;
   level_type           level_op0;
   level_type           level_op1;
   logic [PHASE_W-1:0]  phase_out;

   modport source (output valid, output level_op0, output level_op1, output phase_out,
                   input ready);
   modport sink   (input valid, input level_op0, input level_op1, input phase_out,
                   output ready);
endinterface

### rtl/fm_lfo_vibrato_tremolo.sv
// ----------------------------------------------------------------------------
// FM LFO, vibrato and tremolo
// Tick counter, triangle phase and per-operator level lookup.
// ----------------------------------------------------------------------------
// The result item is registered in the cycle after its tick item is accepted.
// Throughput: one item per cycle; counter update and lookup sit in one stage
// in front of the result register, which holds while the sink stalls.
// Reset: synchronous, active high; clears counter, phase, registers and
// the result valid.
module fm_lfo_vibrato_tremolo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [fvt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fvt_pkg::CSR_DAT_W-1:0]      csr_wdata,
   fvt_req_if.sink                            req_chan,
   fvt_rsp_if.source                          rsp_chan
);
   import fvt_pkg::*;

   function automatic level_type vib_level(input logic [FREQ_W-1:0] f,
                                           input logic [2:0] ph,
                                           input logic deep);
      logic [FREQ_W-1:0]  mag;
      logic               neg;
      logic [LEVEL_W-1:0] val;
      begin
         neg = 1'b0;
         case (ph)
            3'd0: mag = f;
            3'd1: mag = f >> 1;
            3'd2: mag = '0;
            3'd3: begin mag = f >> 1; neg = 1'b1; end
            3'd4: begin mag = f;      neg = 1'b1; end
            3'd5: begin mag = f >> 1; neg = 1'b1; end
            3'd6: mag = '0;
            default: mag = f >> 1;
         endcase
         // shallow halves the magnitude, so negative values round toward zero
         if (!deep) mag = mag >> 1;
         val = {2'b00, mag, 1'b0};
         vib_level = neg ? level_type'(-val) : level_type'(val);
      end
   endfunction

   function automatic level_type trem_level(input logic [PHASE_W-1:0] ph,
                                            input logic deep);
      logic [PHASE_W-1:0] v;
      begin
         v = (ph < TREM_PEAK) ? ph : PHASE_W'(TREM_STEPS - ph);
         if (!deep) v = v >> 2;
         trem_level = level_type'(v);
      end
   endfunction

   logic                 mode_ff, depth0_ff, depth1_ff;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic                 rsp_valid_ff;
   level_type            level0_ff, level0_in;
   level_type            level1_ff, level1_in;
   logic [PHASE_W-1:0]   phase_out_ff;

   logic                 accept;
   logic [TICK_W-1:0]    tick_sum;
   logic [TICK_W-1:0]    dwell;
   logic [PHASE_W-1:0]   phase_step;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      tick_sum = tick_ff + TICK_W'(1);
      if (!mode_ff) begin
         dwell      = VIB_DWELL;
         phase_step = {3'b000, phase_ff[2:0] + 3'd1};
      end else begin
         if (phase_ff == '0) dwell = TREM_DWELL_LOW;
         else if (phase_ff == TREM_PEAK) dwell = TREM_DWELL_PEAK;
         else dwell = TREM_DWELL_MID;
         phase_step = (phase_ff == TREM_LAST) ? '0 : phase_ff + PHASE_W'(1);
      end
      // advance the phase once the dwell is used up
      if (tick_sum >= dwell) begin
         tick_in  = tick_sum - dwell;
         phase_in = phase_step;
      end else begin
         tick_in  = tick_sum;
         phase_in = phase_ff;
      end
      if (mode_ff) begin
         level0_in = trem_level(phase_in, depth0_ff);
         level1_in = trem_level(phase_in, depth1_ff);
      end else begin
         level0_in = vib_level(req_chan.freq_top_bits, phase_in[2:0], depth0_ff);
         level1_in = vib_level(req_chan.freq_top_bits, phase_in[2:0], depth1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         depth0_ff    <= 1'b0;
         depth1_ff    <= 1'b0;
         tick_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LFO_MODE:  mode_ff   <= csr_wdata[0];
               CSR_DEPTH_OP0: depth0_ff <= csr_wdata[0];
               CSR_DEPTH_OP1: depth1_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept) begin
            tick_ff      <= tick_in;
            phase_ff     <= phase_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         level0_ff    <= level0_in;
         level1_ff    <= level1_in;
         phase_out_ff <= phase_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.level_op0 = level0_ff;
   assign rsp_chan.level_op1 = level1_ff;
   assign rsp_chan.phase_out = phase_out_ff;

endmodule

### tb/sv/tb_fm_lfo_vibrato_tremolo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FM LFO vibrato/tremolo testbench
// Streams tick items through the LFO under changing mode and depth settings.
// Predicts the tick counter, the triangle phase and both operator levels,
// then checks every result item in order. Both sides of the pipe idle at random.
// ----------------------------------------------------------------------------
module tb_fm_lfo_vibrato_tremolo;
   import fvt_pkg::*;

   localparam logic [TICK_W-1:0]  VIB_HOLD        = 11'd1024;
   localparam logic [TICK_W-1:0]  TREM_HOLD_FLOOR = 11'd448;
   localparam logic [TICK_W-1:0]  TREM_HOLD_PEAK  = 11'd192;
   localparam logic [TICK_W-1:0]  TREM_HOLD_SLOPE = 11'd256;
   localparam logic [PHASE_W-1:0] TREM_TOP_PHASE  = 6'd26;
   localparam logic [PHASE_W-1:0] TREM_END_PHASE  = 6'd51;
   localparam int                 TREM_SPAN       = 52;

   typedef struct packed {
      level_type          op0;
      level_type          op1;
      logic [PHASE_W-1:0] phase;
   } lfo_levels_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   fvt_req_if req_if ();
   fvt_rsp_if rsp_if ();

   fm_lfo_vibrato_tremolo uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   // Shadow of the block's registers and oscillator state
   bit                 cfg_tremolo;
   bit                 cfg_deep0;
   bit                 cfg_deep1;
   logic [TICK_W-1:0]  lfo_ticks;
   logic [PHASE_W-1:0] lfo_phase;

   logic [FREQ_W-1:0] tick_backlog[$];
   lfo_levels_t       levels_due[$];
   int                fail_count;
   bit                steady_flow;
   int                send_gap;
   int                stall_left;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #150ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 75)
         return 0;
      if (r < 96)
         return $urandom_range(1, 3);
      return $urandom_range(4, 12);
   endfunction

   function automatic level_type operator_level(logic [FREQ_W-1:0] freq, bit deep);
      int full;
      int half;
      int p;
      int lvl;
      full = int'(freq);
      half = full / 2;
      if (cfg_tremolo) begin
         p = int'(lfo_phase) % TREM_SPAN;
         lvl = (p < int'(TREM_TOP_PHASE)) ? p : TREM_SPAN - p;
         if (!deep)
            lvl = lvl / 4;
      end else begin
         // Vibrato looks only at the low three phase bits
         case (lfo_phase[2:0])
            3'd0:       lvl = full;
            3'd1, 3'd7: lvl = half;
            3'd3, 3'd5: lvl = -half;
            3'd4:       lvl = -full;
            default:    lvl = 0;
         endcase
         if (!deep)
            lvl = lvl / 2;
         lvl = lvl * 2;
      end
      return level_type'(lvl);
   endfunction

   task automatic advance_lfo(input logic [FREQ_W-1:0] freq);
      lfo_ticks = lfo_ticks + 1'b1;
      if (!cfg_tremolo) begin
         if (lfo_ticks >= VIB_HOLD) begin
            lfo_phase = (lfo_phase + 1'b1) & 6'd7;
            lfo_ticks = lfo_ticks - VIB_HOLD;
         end
      end else if (lfo_phase == '0) begin
         if (lfo_ticks >= TREM_HOLD_FLOOR) begin
            lfo_phase = 6'd1;
            lfo_ticks = lfo_ticks - TREM_HOLD_FLOOR;
         end
      end else if (lfo_phase == TREM_TOP_PHASE) begin
         if (lfo_ticks >= TREM_HOLD_PEAK) begin
            lfo_phase = TREM_TOP_PHASE + 1'b1;
            lfo_ticks = lfo_ticks - TREM_HOLD_PEAK;
         end
      end else if (lfo_ticks >= TREM_HOLD_SLOPE) begin
         lfo_phase = (lfo_phase >= TREM_END_PHASE) ? '0 : lfo_phase + 1'b1;
         lfo_ticks = lfo_ticks - TREM_HOLD_SLOPE;
      end
      levels_due.push_back('{op0:   operator_level(freq, cfg_deep0),
                             op1:   operator_level(freq, cfg_deep1),
                             phase: lfo_phase});
   endtask

   // Tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            advance_lfo(req_if.freq_top_bits);
         if (req_if.valid && !req_if.ready) begin
            // hold the item until the block takes it
         end else if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (tick_backlog.size() != 0) begin
            req_if.valid         <= 1'b1;
            req_if.freq_top_bits <= tick_backlog.pop_front();
            send_gap = pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      lfo_levels_t want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (levels_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result item: op0 %0d op1 %0d phase %0d",
                           rsp_if.level_op0, rsp_if.level_op1, rsp_if.phase_out);
               fail_count++;
            end else begin
               want = levels_due.pop_front();
               if (rsp_if.level_op0 !== want.op0 || rsp_if.level_op1 !== want.op1 ||
                   rsp_if.phase_out !== want.phase) begin
                  if (fail_count < 10)
                     $display("mismatch at %0t: op0 %0d/%0d op1 %0d/%0d phase %0d/%0d (exp/got)",
                              $realtime, want.op0, rsp_if.level_op0, want.op1,
                              rsp_if.level_op1, want.phase, rsp_if.phase_out);
                  fail_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   task automatic drain_pipeline();
      do begin
         @(posedge clock);
         #1;
      end while (tick_backlog.size() != 0 || req_if.valid || levels_due.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input bit val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LFO_MODE:  cfg_tremolo = val;
         CSR_DEPTH_OP0: cfg_deep0   = val;
         CSR_DEPTH_OP1: cfg_deep1   = val;
         default: ;
      endcase
   endtask

   task automatic set_lfo(input bit tremolo, input bit deep0, input bit deep1);
      drain_pipeline();
      write_reg(CSR_LFO_MODE, tremolo);
      write_reg(CSR_DEPTH_OP0, deep0);
      write_reg(CSR_DEPTH_OP1, deep1);
      steady_flow = ($urandom_range(0, 3) == 0);
   endtask

   task automatic queue_random_ticks(input int count);
      repeat (count)
         tick_backlog.push_back(FREQ_W'($urandom_range(0, 7)));
   endtask

   initial begin
      int n_ticks;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_LFO_MODE;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.freq_top_bits = '0;
      rsp_if.ready         = 1'b0;
      cfg_tremolo          = 1'b0;
      cfg_deep0            = 1'b0;
      cfg_deep1            = 1'b0;
      lfo_ticks            = '0;
      lfo_phase            = '0;
      fail_count           = 0;
      steady_flow          = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Every frequency code at reset settings, then at all registers high
      for (int i = 0; i < 8; i++)
         tick_backlog.push_back(FREQ_W'(i));
      set_lfo(1'b1, 1'b1, 1'b1);
      for (int i = 7; i >= 0; i--)
         tick_backlog.push_back(FREQ_W'(i));

      // Tremolo past the long dwell at phase zero, then vibrato from that phase
      set_lfo(1'b1, 1'b0, 1'b1);
      queue_random_ticks(460);
      set_lfo(1'b0, 1'b1, 1'b0);
      queue_random_ticks(40);

      // Random settings; short runs switch mode while the counter is mid-dwell
      for (int k = 0; k < 10; k++) begin
         set_lfo(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
         n_ticks = $urandom_range(1, 16);
         queue_random_ticks(n_ticks);
      end

      drain_pipeline();
      repeat (8) @(posedge clock);
      if (levels_due.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
